@@ rtl/core/lsmc_pkg.sv @@
// Shared constants, register indexes and saturating arithmetic for the sliding mode controller.
`default_nettype none

package lsmc_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int CFG_WIDTH      = 31;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int PROD_WIDTH     = CFG_WIDTH + DATA_WIDTH;
    localparam int DIV_CNT_WIDTH  = $clog2(FRAC_BITS);

    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_ONE =
        DATA_WIDTH'(64'd1 << FRAC_BITS);
    localparam logic signed [DATA_WIDTH-1:0] SAT_MINUS_ONE = -SAT_ONE;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SURFACE_SLOPE  = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SWITCHING_GAIN = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_ERROR_DEADBAND = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DRIVE_LIMIT    = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_INERTIA        = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_REACHING_GAIN  = 3'd5;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_BOUNDARY_WIDTH = 3'd6;

    // Reset values of the registers
    localparam logic [CFG_WIDTH-1:0] RST_SURFACE_SLOPE  = 31'd1310720;
    localparam logic [CFG_WIDTH-1:0] RST_SWITCHING_GAIN = 31'd7864320;
    localparam logic [CFG_WIDTH-1:0] RST_ERROR_DEADBAND = 31'd66;
    localparam logic [CFG_WIDTH-1:0] RST_DRIVE_LIMIT    = 31'd458752;
    localparam logic [CFG_WIDTH-1:0] RST_INERTIA        = 31'd65536;
    localparam logic [CFG_WIDTH-1:0] RST_REACHING_GAIN  = 31'd32768;
    localparam logic [CFG_WIDTH-1:0] RST_BOUNDARY_WIDTH = 31'd65536;

    // Add or subtract, saturated to the data width
    function automatic logic signed [DATA_WIDTH-1:0] sat_addsub(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b,
        input logic                         sub
    );
        logic signed [DATA_WIDTH:0] ea;
        logic signed [DATA_WIDTH:0] eb;
        logic signed [DATA_WIDTH:0] sum;
        ea  = {a[DATA_WIDTH-1], a};
        eb  = {b[DATA_WIDTH-1], b};
        sum = sub ? (ea - eb) : (ea + eb);
        if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1])
            return sum[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        return sum[DATA_WIDTH-1:0];
    endfunction

    // Magnitude of a signed value, as unsigned (the most negative value maps to 2^(W-1))
    function automatic logic [DATA_WIDTH-1:0] magnitude(input logic signed [DATA_WIDTH-1:0] a);
        return a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
    endfunction

    // Scale a magnitude product down by the fraction bits, apply the sign and saturate
    function automatic logic signed [DATA_WIDTH-1:0] qmul_finish(
        input logic [PROD_WIDTH-1:0] prod,
        input logic                  neg
    );
        logic                  big;
        logic [DATA_WIDTH-1:0] r;
        big = |prod[PROD_WIDTH-1:FRAC_BITS+DATA_WIDTH-1];
        r   = {1'b0, prod[FRAC_BITS+DATA_WIDTH-2:FRAC_BITS]};
        if (big)
            return neg ? DATA_MIN : DATA_MAX;
        return neg ? -r : r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/linear_sliding_mode_controller.sv @@
// Sliding mode controller with boundary layer: sequencer around one shared adder and multiplier.
//
// Usage: each control tick send one item on the s_axis channel (angular rate, angle and
// target angle, signed Q16.16) and take one item, the drive, on the m_axis channel.
// Gains and limits are set on the cfg port (cfg_we, cfg_addr, cfg_wdata) while the block
// is idle; a write to an unknown index is dropped.
// One item is worked on at a time: s_axis_tready is high only while the sequencer is idle.
// The work runs through one saturating adder, one 31x32 multiplier with a registered
// product and a one-bit-per-cycle divider for the boundary layer ratio.
// Path from the accepting edge to the drive being valid on m_axis:
//   straight to the clamp step when the angle error lies inside the deadband,
//   the chain without the divider when the surface is zero or outside the boundary layer,
//   the chain plus the divider inside the boundary layer (16 divider steps).
// A new item is taken on the cycle after the drive is loaded into the output register.
// The output register holds the drive while the receiver stalls; the next item is still
// accepted and the sequencer waits only if its own drive is ready before the last one left.
// Reset clears the target history and loads the register defaults; no item is pending.
`default_nettype none

module linear_sliding_mode_controller
    import lsmc_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,
    // Input items
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [3*DATA_WIDTH-1:0]      s_axis_tdata,  // angular_rate, angle, target_angle
    // Result items
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [DATA_WIDTH-1:0]        m_axis_tdata,  // drive
    // Configuration writes
    input  wire                          cfg_we,
    input  wire  [CFG_ADDR_WIDTH-1:0]    cfg_addr,
    input  wire  [CFG_WIDTH-1:0]         cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STEP,
        ST_DSTEP,
        ST_ERR,
        ST_DEAD,
        ST_MUL_CE,
        ST_FIN_CE,
        ST_S_ADD,
        ST_S_SUB,
        ST_V,
        ST_MUL_CV,
        ST_FIN_CV,
        ST_T_CV,
        ST_SAT,
        ST_DIV,
        ST_MUL_EPS,
        ST_FIN_EPS,
        ST_T_EPS,
        ST_MUL_K,
        ST_FIN_K,
        ST_T_K,
        ST_MUL_J,
        ST_FIN_J,
        ST_CLAMP
    } state_t;

    // Configuration registers
    logic [CFG_WIDTH-1:0] slope_reg;
    logic [CFG_WIDTH-1:0] kgain_reg;
    logic [CFG_WIDTH-1:0] deadband_reg;
    logic [CFG_WIDTH-1:0] limit_reg;
    logic [CFG_WIDTH-1:0] inertia_reg;
    logic [CFG_WIDTH-1:0] eps_reg;
    logic [CFG_WIDTH-1:0] phi_reg;

    // Sequencer state and working registers
    state_t                         state_reg, state_next;
    logic signed [DATA_WIDTH-1:0]   rate_reg, rate_next;
    logic signed [DATA_WIDTH-1:0]   ang_reg, ang_next;
    logic signed [DATA_WIDTH-1:0]   tgt_reg, tgt_next;
    logic signed [DATA_WIDTH-1:0]   prev_tgt_reg, prev_tgt_next;
    logic signed [DATA_WIDTH-1:0]   prev_step_reg, prev_step_next;
    logic signed [DATA_WIDTH-1:0]   step_reg, step_next;
    logic signed [DATA_WIDTH-1:0]   dstep_reg, dstep_next;
    logic signed [DATA_WIDTH-1:0]   err_reg, err_next;
    logic signed [DATA_WIDTH-1:0]   s_reg, s_next;
    logic signed [DATA_WIDTH-1:0]   v_reg, v_next;
    logic signed [DATA_WIDTH-1:0]   t_reg, t_next;
    logic signed [DATA_WIDTH-1:0]   q_reg, q_next;
    logic signed [DATA_WIDTH-1:0]   sat_reg, sat_next;
    logic [PROD_WIDTH-1:0]          prod_reg, prod_next;
    logic                           neg_reg, neg_next;
    logic [CFG_WIDTH-1:0]           rem_reg, rem_next;
    logic [FRAC_BITS-1:0]           quo_reg, quo_next;
    logic [DIV_CNT_WIDTH-1:0]       cnt_reg, cnt_next;
    logic signed [DATA_WIDTH-1:0]   drive_reg, drive_next;
    logic                           out_valid_reg, out_valid_next;

    // Shared units
    logic signed [DATA_WIDTH-1:0]   add_a, add_b, add_res;
    logic                           add_sub;
    logic [CFG_WIDTH-1:0]           mul_a;
    logic signed [DATA_WIDTH-1:0]   mul_b;
    logic [DATA_WIDTH-1:0]          mul_mag;
    logic [PROD_WIDTH-1:0]          mul_prod;
    logic signed [DATA_WIDTH-1:0]   mul_fin;

    // Divider step and compares
    logic [CFG_WIDTH:0]             rem_dbl;
    logic [CFG_WIDTH:0]             rem_diff;
    logic                           rem_ge;
    logic [FRAC_BITS-1:0]           quo_shift;
    logic signed [DATA_WIDTH-1:0]   quo_ext;
    logic signed [DATA_WIDTH-1:0]   phi_s;
    logic signed [DATA_WIDTH-1:0]   limit_s;
    logic [DATA_WIDTH-1:0]          err_mag;
    logic [DATA_WIDTH-1:0]          s_mag;

    assign add_res  = sat_addsub(add_a, add_b, add_sub);
    assign mul_mag  = magnitude(mul_b);
    assign mul_prod = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_mag);
    assign mul_fin  = qmul_finish(prod_reg, neg_reg);

    assign rem_dbl   = {rem_reg, 1'b0};
    assign rem_ge    = rem_dbl >= {1'b0, phi_reg};
    assign rem_diff  = rem_dbl - {1'b0, phi_reg};
    assign quo_shift = {quo_reg[FRAC_BITS-2:0], rem_ge};
    assign quo_ext   = DATA_WIDTH'(quo_shift);

    assign phi_s   = {1'b0, phi_reg};
    assign limit_s = {1'b0, limit_reg};
    assign err_mag = magnitude(err_reg);
    assign s_mag   = magnitude(s_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = drive_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg    <= RST_SURFACE_SLOPE;
            kgain_reg    <= RST_SWITCHING_GAIN;
            deadband_reg <= RST_ERROR_DEADBAND;
            limit_reg    <= RST_DRIVE_LIMIT;
            inertia_reg  <= RST_INERTIA;
            eps_reg      <= RST_REACHING_GAIN;
            phi_reg      <= RST_BOUNDARY_WIDTH;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SURFACE_SLOPE:  slope_reg    <= cfg_wdata;
                REG_SWITCHING_GAIN: kgain_reg    <= cfg_wdata;
                REG_ERROR_DEADBAND: deadband_reg <= cfg_wdata;
                REG_DRIVE_LIMIT:    limit_reg    <= cfg_wdata;
                REG_INERTIA:        inertia_reg  <= cfg_wdata;
                REG_REACHING_GAIN:  eps_reg      <= cfg_wdata;
                REG_BOUNDARY_WIDTH: phi_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer: at most one adder operation or one multiplier step per cycle
    always_comb
    begin
        state_next     = state_reg;
        rate_next      = rate_reg;
        ang_next       = ang_reg;
        tgt_next       = tgt_reg;
        prev_tgt_next  = prev_tgt_reg;
        prev_step_next = prev_step_reg;
        step_next      = step_reg;
        dstep_next     = dstep_reg;
        err_next       = err_reg;
        s_next         = s_reg;
        v_next         = v_reg;
        t_next         = t_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        add_a   = tgt_reg;
        add_b   = prev_tgt_reg;
        add_sub = 1'b1;
        mul_a   = slope_reg;
        mul_b   = err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    rate_next  = s_axis_tdata[DATA_WIDTH-1:0];
                    ang_next   = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
                    tgt_next   = s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                step_next  = add_res;
                state_next = ST_DSTEP;
            end
            ST_DSTEP:
            begin
                add_a          = step_reg;
                add_b          = prev_step_reg;
                dstep_next     = add_res;
                prev_tgt_next  = tgt_reg;
                prev_step_next = step_reg;
                state_next     = ST_ERR;
            end
            ST_ERR:
            begin
                add_a      = ang_reg;
                add_b      = tgt_reg;
                err_next   = add_res;
                state_next = ST_DEAD;
            end
            ST_DEAD:
            begin
                if (err_mag < {1'b0, deadband_reg})
                begin
                    t_next     = '0;
                    state_next = ST_CLAMP;
                end
                else
                    state_next = ST_MUL_CE;
            end
            ST_MUL_CE:
            begin
                prod_next  = mul_prod;
                neg_next   = mul_b[DATA_WIDTH-1];
                state_next = ST_FIN_CE;
            end
            ST_FIN_CE:
            begin
                q_next     = mul_fin;
                state_next = ST_S_ADD;
            end
            ST_S_ADD:
            begin
                add_a      = q_reg;
                add_b      = rate_reg;
                add_sub    = 1'b0;
                s_next     = add_res;
                state_next = ST_S_SUB;
            end
            ST_S_SUB:
            begin
                add_a      = s_reg;
                add_b      = step_reg;
                s_next     = add_res;
                state_next = ST_V;
            end
            ST_V:
            begin
                add_a      = rate_reg;
                add_b      = step_reg;
                v_next     = add_res;
                state_next = ST_MUL_CV;
            end
            ST_MUL_CV:
            begin
                mul_b      = v_reg;
                prod_next  = mul_prod;
                neg_next   = mul_b[DATA_WIDTH-1];
                state_next = ST_FIN_CV;
            end
            ST_FIN_CV:
            begin
                q_next     = mul_fin;
                state_next = ST_T_CV;
            end
            ST_T_CV:
            begin
                add_a      = dstep_reg;
                add_b      = q_reg;
                t_next     = add_res;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                // Zero surface, outside the layer, or start the ratio |s|/phi
                if (s_reg == '0)
                begin
                    sat_next   = '0;
                    state_next = ST_MUL_EPS;
                end
                else if (s_reg >= phi_s)
                begin
                    sat_next   = SAT_ONE;
                    state_next = ST_MUL_EPS;
                end
                else if (s_reg <= -phi_s)
                begin
                    sat_next   = SAT_MINUS_ONE;
                    state_next = ST_MUL_EPS;
                end
                else
                begin
                    rem_next   = s_mag[CFG_WIDTH-1:0];
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? rem_diff[CFG_WIDTH-1:0] : rem_dbl[CFG_WIDTH-1:0];
                quo_next = quo_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_WIDTH'(FRAC_BITS - 1))
                begin
                    sat_next   = s_reg[DATA_WIDTH-1] ? -quo_ext : quo_ext;
                    state_next = ST_MUL_EPS;
                end
            end
            ST_MUL_EPS:
            begin
                mul_a      = eps_reg;
                mul_b      = sat_reg;
                prod_next  = mul_prod;
                neg_next   = mul_b[DATA_WIDTH-1];
                state_next = ST_FIN_EPS;
            end
            ST_FIN_EPS:
            begin
                q_next     = mul_fin;
                state_next = ST_T_EPS;
            end
            ST_T_EPS:
            begin
                add_a      = t_reg;
                add_b      = q_reg;
                t_next     = add_res;
                state_next = ST_MUL_K;
            end
            ST_MUL_K:
            begin
                mul_a      = kgain_reg;
                mul_b      = s_reg;
                prod_next  = mul_prod;
                neg_next   = mul_b[DATA_WIDTH-1];
                state_next = ST_FIN_K;
            end
            ST_FIN_K:
            begin
                q_next     = mul_fin;
                state_next = ST_T_K;
            end
            ST_T_K:
            begin
                add_a      = t_reg;
                add_b      = q_reg;
                t_next     = add_res;
                state_next = ST_MUL_J;
            end
            ST_MUL_J:
            begin
                mul_a      = inertia_reg;
                mul_b      = t_reg;
                prod_next  = mul_prod;
                neg_next   = mul_b[DATA_WIDTH-1];
                state_next = ST_FIN_J;
            end
            ST_FIN_J:
            begin
                t_next     = mul_fin;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // Hold here while the previous drive still waits on the receiver
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (t_reg > limit_s)
                        drive_next = limit_s;
                    else if (t_reg < -limit_s)
                        drive_next = -limit_s;
                    else
                        drive_next = t_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_tgt_reg  <= '0;
            prev_step_reg <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_tgt_reg  <= prev_tgt_next;
            prev_step_reg <= prev_step_next;
            out_valid_reg <= out_valid_next;
            drive_reg     <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg  <= rate_next;
        ang_reg   <= ang_next;
        tgt_reg   <= tgt_next;
        step_reg  <= step_next;
        dstep_reg <= dstep_next;
        err_reg   <= err_next;
        s_reg     <= s_next;
        v_reg     <= v_next;
        t_reg     <= t_next;
        q_reg     <= q_next;
        sat_reg   <= sat_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
    end

    // A waiting drive never leaves the symmetric limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_reg <= limit_s) && (drive_reg >= -limit_s))
        else $error("drive outside limit");

    // The boundary layer term is within plus or minus one before it is scaled
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_EPS) |-> (sat_reg <= SAT_ONE) && (sat_reg >= SAT_MINUS_ONE))
        else $error("saturation term out of range");

    // An accepted item closes the input until its drive is formed
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened during work");

    // A new drive only appears from the clamp step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_CLAMP))
        else $error("drive valid without clamp step");

endmodule

`default_nettype wire
